/* hdl/assert_macros.svh */
// Assertion macros used by the checker file cau_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define CAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define CAU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/cau_pkg.sv */
// Shared widths, operation codes and control struct of the complex ALU.
// No dependencies.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PW     = 2 * DATA_WIDTH;        // product width
  localparam int MAG_W  = PW;                    // magnitude of a product sum
  localparam int DEN_W  = PW;                    // squared magnitude of B
  localparam int QB     = DATA_WIDTH + 1;        // quotient bits kept
  localparam int REM_W  = MAG_W + QB + 2;        // remainder / shifted divisor
  localparam int NSTG   = QB + 1;                // divider stages (overflow step, then one bit each)

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cau_cmd_e;

  typedef struct packed {
    cau_cmd_e cmd;
    logic     neg_r;
    logic     neg_i;
    logic     dz;
  } cau_ctl_t;

endpackage

/* hdl/complex_arithmetic_unit.sv */
// Complex ALU: add, subtract, multiply, divide on signed Q8.8 operands.
// Stages: 3 front stages, 18 divider stages (an overflow step, then one quotient bit each), 1 output.
// Throughput one beat per cycle for every operation unless out_ready_i stalls; all ops share the divider pipe.
// Each stage stalls only when full and blocked, so bubbles are absorbed.
// rst_ni clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] res_real_o,
  output logic signed [DATA_WIDTH-1:0] res_imag_o,
  output logic                         div_zero_o,
  output logic                         saturated_o
);

  logic             f_valid, f_ready, d_valid, d_ready;
  cau_ctl_t         f_ctl, d_ctl;
  logic [MAG_W-1:0] f_mr, f_mi, d_mr, d_mi;
  logic [DEN_W-1:0] f_den;

  cau_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i, .a_real_i, .a_imag_i, .b_real_i, .b_imag_i,
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .ctl_o       (f_ctl),
    .mag_r_o     (f_mr),
    .mag_i_o     (f_mi),
    .den_o       (f_den)
  );

  cau_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .ctl_i       (f_ctl),
    .mag_r_i     (f_mr),
    .mag_i_i     (f_mi),
    .den_i       (f_den),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .ctl_o       (d_ctl),
    .mag_r_o     (d_mr),
    .mag_i_o     (d_mi)
  );

  cau_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .ctl_i       (d_ctl),
    .mag_r_i     (d_mr),
    .mag_i_i     (d_mi),
    .out_valid_o, .out_ready_i,
    .res_real_o, .res_imag_o, .div_zero_o, .saturated_o
  );

endmodule

/* hdl/cau_front.sv */
// Front end: input register, product stage, and sum / sign-magnitude stage.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cau_ctl_t                     ctl_o,
  output logic [MAG_W-1:0]             mag_r_o,
  output logic [MAG_W-1:0]             mag_i_o,
  output logic [DEN_W-1:0]             den_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: operand register
  cau_cmd_e                    s1_cmd_q;
  logic signed [DATA_WIDTH-1:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_cmd_q <= cau_cmd_e'(cmd_i);
      s1_a_q   <= a_real_i;
      s1_b_q   <= a_imag_i;
      s1_c_q   <= b_real_i;
      s1_d_q   <= b_imag_i;
    end
  end

  // Stage 2: products and plain sums
  cau_cmd_e              s2_cmd_q;
  logic                  s2_bz_q;
  logic signed [PW-1:0]  s2_ac_q, s2_bd_q, s2_ad_q, s2_bc_q, s2_cc_q, s2_dd_q;
  logic signed [DATA_WIDTH:0] s2_sr_q, s2_si_q;
  logic signed [DATA_WIDTH:0] sr_d, si_d;
  logic signed [DATA_WIDTH:0] ae, be, ce, de;

  always_comb begin
    ae = {s1_a_q[DATA_WIDTH-1], s1_a_q};
    be = {s1_b_q[DATA_WIDTH-1], s1_b_q};
    ce = {s1_c_q[DATA_WIDTH-1], s1_c_q};
    de = {s1_d_q[DATA_WIDTH-1], s1_d_q};
    if (s1_cmd_q == CMD_SUB) begin
      sr_d = ae - ce;
      si_d = be - de;
    end else begin
      sr_d = ae + ce;
      si_d = be + de;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_cmd_q <= s1_cmd_q;
      s2_bz_q  <= (s1_c_q == '0) && (s1_d_q == '0);
      s2_ac_q  <= s1_a_q * s1_c_q;
      s2_bd_q  <= s1_b_q * s1_d_q;
      s2_ad_q  <= s1_a_q * s1_d_q;
      s2_bc_q  <= s1_b_q * s1_c_q;
      s2_cc_q  <= s1_c_q * s1_c_q;
      s2_dd_q  <= s1_d_q * s1_d_q;
      s2_sr_q  <= sr_d;
      s2_si_q  <= si_d;
    end
  end

  // Stage 3: combine products, split into sign and magnitude
  logic signed [PW:0]  vr, vi, mr_full, mi_full;
  logic signed [PW:0]  ac, bd, ad, bc;
  cau_ctl_t            ctl_d;
  logic [MAG_W-1:0]    mr_d, mi_d;

  always_comb begin
    ac = {s2_ac_q[PW-1], s2_ac_q};
    bd = {s2_bd_q[PW-1], s2_bd_q};
    ad = {s2_ad_q[PW-1], s2_ad_q};
    bc = {s2_bc_q[PW-1], s2_bc_q};
    unique case (s2_cmd_q)
      CMD_MUL: begin
        vr = ac - bd;
        vi = ad + bc;
      end
      CMD_DIV: begin
        vr = ac + bd;
        vi = bc - ad;
      end
      default: begin
        vr = {{(PW-DATA_WIDTH){s2_sr_q[DATA_WIDTH]}}, s2_sr_q};
        vi = {{(PW-DATA_WIDTH){s2_si_q[DATA_WIDTH]}}, s2_si_q};
      end
    endcase
    mr_full   = vr[PW] ? -vr : vr;
    mi_full   = vi[PW] ? -vi : vi;
    mr_d      = mr_full[MAG_W-1:0];
    mi_d      = mi_full[MAG_W-1:0];
    // multiply product sums drop the fraction, truncating the magnitude
    if (s2_cmd_q == CMD_MUL) begin
      mr_d = mr_d >> FRAC_BITS;
      mi_d = mi_d >> FRAC_BITS;
    end
    ctl_d.cmd   = s2_cmd_q;
    ctl_d.neg_r = vr[PW];
    ctl_d.neg_i = vi[PW];
    ctl_d.dz    = (s2_cmd_q == CMD_DIV) && s2_bz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      ctl_o   <= ctl_d;
      mag_r_o <= mr_d;
      mag_i_o <= mi_d;
      den_o   <= s2_cc_q[DEN_W-1:0] + s2_dd_q[DEN_W-1:0];
    end
  end

  assign out_valid_o = v3_q;

endmodule

/* hdl/cau_div.sv */
// Pipelined restoring divider: an overflow step, then one quotient bit per stage; two
// lanes share the divisor. Non-divide and zero-divisor beats pass magnitudes through. Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_div import cau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cau_ctl_t         ctl_i,
  input  logic [MAG_W-1:0] mag_r_i,
  input  logic [MAG_W-1:0] mag_i_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cau_ctl_t         ctl_o,
  output logic [MAG_W-1:0] mag_r_o,
  output logic [MAG_W-1:0] mag_i_o
);

  logic             v_q   [NSTG];
  logic             en    [NSTG];
  cau_ctl_t         ctl_q [NSTG];
  logic [DEN_W-1:0] den_q [NSTG];
  logic [REM_W-1:0] rr_q  [NSTG];
  logic [REM_W-1:0] ri_q  [NSTG];
  logic [QB-1:0]    qr_q  [NSTG];
  logic [QB-1:0]    qi_q  [NSTG];
  logic             ovr_q [NSTG];
  logic             ovi_q [NSTG];

  logic             vin   [NSTG];
  cau_ctl_t         cin   [NSTG];
  logic [DEN_W-1:0] din   [NSTG];
  logic [REM_W-1:0] rrin  [NSTG];
  logic [REM_W-1:0] riin  [NSTG];
  logic [QB-1:0]    qrin  [NSTG];
  logic [QB-1:0]    qiin  [NSTG];
  logic             ovrin [NSTG];
  logic             oviin [NSTG];

  logic in_div;
  assign in_div = (ctl_i.cmd == CMD_DIV) && !ctl_i.dz;

  assign vin[0]   = in_valid_i;
  assign cin[0]   = ctl_i;
  assign din[0]   = den_i;
  assign rrin[0]  = in_div ? (REM_W'(mag_r_i) << FRAC_BITS) : REM_W'(mag_r_i);
  assign riin[0]  = in_div ? (REM_W'(mag_i_i) << FRAC_BITS) : REM_W'(mag_i_i);
  assign qrin[0]  = '0;
  assign qiin[0]  = '0;
  assign ovrin[0] = 1'b0;
  assign oviin[0] = 1'b0;
  assign in_ready_o = en[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int SH = QB - k;
    logic             act;
    logic [REM_W-1:0] dsh;
    logic             ge_r, ge_i;

    if (k > 0) begin : g_link
      assign vin[k]   = v_q[k-1];
      assign cin[k]   = ctl_q[k-1];
      assign din[k]   = den_q[k-1];
      assign rrin[k]  = rr_q[k-1];
      assign riin[k]  = ri_q[k-1];
      assign qrin[k]  = qr_q[k-1];
      assign qiin[k]  = qi_q[k-1];
      assign ovrin[k] = ovr_q[k-1];
      assign oviin[k] = ovi_q[k-1];
    end

    if (k == NSTG - 1) begin : g_last
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign act  = (cin[k].cmd == CMD_DIV) && !cin[k].dz;
    assign dsh  = REM_W'(din[k]) << SH;
    assign ge_r = act && (rrin[k] >= dsh);
    assign ge_i = act && (riin[k] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin[k];
      end
    end

    // top step sets no quotient bit; it flags a quotient too large for the kept bits
    always_ff @(posedge clk_i) begin
      if (en[k] && vin[k]) begin
        ctl_q[k] <= cin[k];
        den_q[k] <= din[k];
        rr_q[k]  <= ge_r ? rrin[k] - dsh : rrin[k];
        ri_q[k]  <= ge_i ? riin[k] - dsh : riin[k];
        qr_q[k]  <= (k == 0) ? qrin[k] : (qrin[k] | (QB'(ge_r) << SH));
        qi_q[k]  <= (k == 0) ? qiin[k] : (qiin[k] | (QB'(ge_i) << SH));
        ovr_q[k] <= (k == 0) ? ge_r : ovrin[k];
        ovi_q[k] <= (k == 0) ? ge_i : oviin[k];
      end
    end
  end

  logic last_div;
  assign last_div    = (ctl_q[NSTG-1].cmd == CMD_DIV) && !ctl_q[NSTG-1].dz;
  assign out_valid_o = v_q[NSTG-1];
  assign ctl_o       = ctl_q[NSTG-1];

  always_comb begin
    if (last_div) begin
      mag_r_o = ovr_q[NSTG-1] ? MAG_W'(1) << DATA_WIDTH : MAG_W'(qr_q[NSTG-1]);
      mag_i_o = ovi_q[NSTG-1] ? MAG_W'(1) << DATA_WIDTH : MAG_W'(qi_q[NSTG-1]);
    end else begin
      mag_r_o = rr_q[NSTG-1][MAG_W-1:0];
      mag_i_o = ri_q[NSTG-1][MAG_W-1:0];
    end
  end

endmodule

/* hdl/cau_back.sv */
// Output stage: saturate sign-magnitude results, raise flags, hold the beat.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cau_ctl_t                      ctl_i,
  input  logic [MAG_W-1:0]              mag_r_i,
  input  logic [MAG_W-1:0]              mag_i_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]  res_real_o,
  output logic signed [DATA_WIDTH-1:0]  res_imag_o,
  output logic                          div_zero_o,
  output logic                          saturated_o
);

  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (DATA_WIDTH - 1);

  logic                   vq;
  logic                   en;
  logic [DATA_WIDTH-1:0]  rr, ri;
  logic                   sr, si;

  function automatic logic [DATA_WIDTH:0] clip(input logic neg, input logic [MAG_W-1:0] mag);
    logic [DATA_WIDTH-1:0] lo;
    logic                  s;
    lo = mag[DATA_WIDTH-1:0];
    s  = 1'b0;
    if (neg) begin
      if (mag > NEG_LIM) begin
        s  = 1'b1;
        lo = NEG_LIM[DATA_WIDTH-1:0];
      end else begin
        lo = -lo;
      end
    end else if (mag > NEG_LIM - MAG_W'(1)) begin
      s  = 1'b1;
      lo = NEG_LIM[DATA_WIDTH-1:0] - DATA_WIDTH'(1);
    end
    return {s, lo};
  endfunction

  assign en         = !vq || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    {sr, rr} = clip(ctl_i.neg_r, mag_r_i);
    {si, ri} = clip(ctl_i.neg_i, mag_i_i);
    // divide by zero: force zero, no saturation
    if (ctl_i.dz) begin
      rr = '0;
      ri = '0;
      sr = 1'b0;
      si = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      res_real_o  <= rr;
      res_imag_o  <= ri;
      div_zero_o  <= ctl_i.dz;
      saturated_o <= sr || si;
    end
  end

  assign out_valid_o = vq;

endmodule

/* hdl/cau_checker.sv */
// Port-level checks for complex_arithmetic_unit, bound to the top level.
// Depends on cau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cau_checker import cau_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] res_real_o,
  input logic signed [DATA_WIDTH-1:0] res_imag_o,
  input logic                         div_zero_o,
  input logic                         saturated_o
);

  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  `CAU_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o, "valid during reset")
  `CAU_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_real_o) && $stable(res_imag_o), "stalled beat changed")
  `CAU_ASSERT(a_dz_zero, clk_i, rst_ni, out_valid_o && div_zero_o |-> res_real_o == '0 && res_imag_o == '0 && !saturated_o, "divide by zero result not cleared")
  `CAU_ASSERT(a_sat_rail, clk_i, rst_ni, out_valid_o && saturated_o |-> res_real_o == MAXV || res_real_o == MINV || res_imag_o == MAXV || res_imag_o == MINV, "saturation without a rail value")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i,
  .res_real_o, .res_imag_o, .div_zero_o, .saturated_o
);

/* tb/tb_top.sv */
// Self-checking testbench for complex_arithmetic_unit: directed table, then random beats.
// Depends on cau_pkg and the RTL of complex_arithmetic_unit.
`timescale 1ns / 1ps
module tb_top;
  import cau_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM       = 1430;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         dz;
    logic                         sat;
  } cplx_res_t;

  typedef struct {
    cau_cmd_e                     cmd;
    logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
    logic                         typed;
    cplx_res_t                    res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_ADD;
  logic signed [DATA_WIDTH-1:0] a_real_i = '0, a_imag_i = '0, b_real_i = '0, b_imag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DATA_WIDTH-1:0] res_real_o, res_imag_o;
  logic div_zero_o, saturated_o;

  cplx_res_t expected_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        timed_out = 1'b0;

  always #1 clk_i = ~clk_i;

  complex_arithmetic_unit dut (.*);

  localparam longint MAXV = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint MINV = -(64'sd1 <<< (DATA_WIDTH - 1));

  function automatic longint clip_part(longint v, ref logic sat);
    if (v > MAXV) begin
      sat = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      sat = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  // Truncate toward zero: scale magnitude, restore sign.
  function automatic longint scale_mul(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint scale_div(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m <<< FRAC_BITS) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_result(cau_cmd_e cmd, longint a, longint b,
                                               longint c, longint d);
    cplx_res_t r;
    longint    pr, pi, den;
    logic      sat;
    sat = 1'b0;
    r.dz = 1'b0;
    pr = 0;
    pi = 0;
    case (cmd)
      CMD_ADD: begin
        pr = a + c;
        pi = b + d;
      end
      CMD_SUB: begin
        pr = a - c;
        pi = b - d;
      end
      CMD_MUL: begin
        pr = scale_mul(a * c - b * d);
        pi = scale_mul(a * d + b * c);
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) r.dz = 1'b1;
        else begin
          pr = scale_div(a * c + b * d, den);
          pi = scale_div(b * c - a * d, den);
        end
      end
    endcase
    r.re = DATA_WIDTH'(clip_part(pr, sat));
    r.im = DATA_WIDTH'(clip_part(pi, sat));
    r.sat = sat;
    return r;
  endfunction

  // Hold valid from the previous beat when there is no gap; drop it only to idle.
  task automatic send_beat(cau_cmd_e cmd, logic signed [DATA_WIDTH-1:0] ar, ai, br, bi,
                           logic typed, cplx_res_t typed_res);
    int gap;
    cplx_res_t pred;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pred = complex_result(cmd, ar, ai, br, bi);
    if (typed && pred !== typed_res && mismatches < 10)
      $display("table row mismatch cmd %0d: exp re %0d im %0d dz %b sat %b, got re %0d im %0d dz %b sat %b",
               cmd, typed_res.re, typed_res.im, typed_res.dz, typed_res.sat,
               pred.re, pred.im, pred.dz, pred.sat);
    if (typed && pred !== typed_res) mismatches++;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    a_real_i   <= ar;
    a_imag_i   <= ai;
    b_real_i   <= br;
    b_imag_i   <= bi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(typed ? typed_res : pred);
  endtask

  // Result side: random stall per beat, compare on acceptance.
  initial begin
    int        stall;
    cplx_res_t got, want;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{res_real_o, res_imag_o, div_zero_o, saturated_o};
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat re %0d im %0d", got.re, got.im);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: exp re %0d im %0d dz %b sat %b, got re %0d im %0d dz %b sat %b",
                     want.re, want.im, want.dz, want.sat, got.re, got.im, got.dz, got.sat);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [DATA_WIDTH-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return DATA_WIDTH'(MAXV);
      1: return DATA_WIDTH'(MINV);
      2: return DATA_WIDTH'($urandom_range(0, 1023) - 512);
      3: return DATA_WIDTH'($urandom_range(0, 4095) - 2048);
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  stim_row_t dir_table[$];

  task automatic add_row(cau_cmd_e cmd, longint ar, ai, br, bi, logic typed = 1'b0,
                         longint rr = 0, longint ri = 0, logic dz = 1'b0, logic sat = 1'b0);
    stim_row_t row;
    row.cmd = cmd;
    row.ar = DATA_WIDTH'(ar);
    row.ai = DATA_WIDTH'(ai);
    row.br = DATA_WIDTH'(br);
    row.bi = DATA_WIDTH'(bi);
    row.typed = typed;
    row.res = '{DATA_WIDTH'(rr), DATA_WIDTH'(ri), dz, sat};
    dir_table.push_back(row);
  endtask

  initial begin
    cau_cmd_e cmd;
    logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
    add_row(CMD_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(CMD_ADD, MAXV, MINV, 1, -1, 1, MAXV, MINV, 0, 1);
    add_row(CMD_ADD, MAXV, MAXV, MINV, MINV, 1, -1, -1, 0, 0);
    add_row(CMD_SUB, MINV, MAXV, 1, -1, 1, MINV, MAXV, 0, 1);
    add_row(CMD_SUB, MAXV, MINV, MAXV, MINV, 1, 0, 0, 0, 0);
    add_row(CMD_MUL, 256, 0, 256, 0, 1, 256, 0, 0, 0);
    add_row(CMD_MUL, MAXV, MAXV, MAXV, MAXV, 1, 0, MAXV, 0, 1);
    add_row(CMD_MUL, MINV, MINV, MINV, MINV);
    add_row(CMD_MUL, -1, 0, 1, 0, 1, 0, 0, 0, 0);
    add_row(CMD_MUL, -300, 77, 129, -5);
    add_row(CMD_DIV, 100, -100, 0, 0, 1, 0, 0, 1, 0);
    add_row(CMD_DIV, MAXV, MINV, 0, 0, 1, 0, 0, 1, 0);
    add_row(CMD_DIV, 256, 0, 256, 0, 1, 256, 0, 0, 0);
    add_row(CMD_DIV, MAXV, MAXV, 1, 0);
    add_row(CMD_DIV, MINV, MINV, 0, -1);
    add_row(CMD_DIV, 1, 1, MAXV, MINV);
    add_row(CMD_DIV, -1, 0, 3, 0);
    add_row(CMD_DIV, -700, 333, 17, -91);
    add_row(CMD_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    add_row(CMD_SUB, -1, -1, MAXV, MAXV);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_table[k])
      send_beat(dir_table[k].cmd, dir_table[k].ar, dir_table[k].ai, dir_table[k].br,
                dir_table[k].bi, dir_table[k].typed, dir_table[k].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Drain the pipe once, midway.
      if (n == N_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      cmd = cau_cmd_e'($urandom_range(0, 3));
      ar = rand_operand();
      ai = rand_operand();
      br = rand_operand();
      bi = rand_operand();
      if (cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_beat(cmd, ar, ai, br, bi, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
